// ----- src/mcps_pkg.sv -----
// Shared types, codes and constants for the MQTT control packet serializer.
`timescale 1ns / 1ps

package mcps_pkg;

	// Input item kinds.
	localparam logic [2:0] KIND_CONNACK  = 3'd0;
	localparam logic [2:0] KIND_PUBLISH  = 3'd1;
	localparam logic [2:0] KIND_SUBACK   = 3'd2;
	localparam logic [2:0] KIND_PINGRESP = 3'd3;
	localparam logic [2:0] KIND_BODY     = 3'd4;

	// Fixed header bytes.
	localparam logic [7:0] CONNACK_HDR  = 8'h20;
	localparam logic [7:0] CONNACK_LEN  = 8'h02;
	localparam logic [7:0] PUBLISH_HDR  = 8'h30;
	localparam logic [7:0] SUBACK_HDR   = 8'h90;
	localparam logic [7:0] PINGRESP_HDR = 8'hD0;
	localparam logic [7:0] ZERO_BYTE    = 8'h00;

	// Most bytes a single item can produce, and the width of a byte count.
	localparam int MAX_BYTES = 9;
	localparam int CNT_W     = 4;

	// Default depth of the command queue between front and back.
	localparam int QUEUE_DEPTH = 4;

	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_TOPIC   = 2'd1,
		PH_PAYLOAD = 2'd2,
		PH_CODES   = 2'd3
	} phase_t;

	// One command: the bytes an accepted item produces, in order.
	typedef struct packed {
		logic [MAX_BYTES-1:0][7:0] bytes;
		logic [CNT_W-1:0]          count;
		logic                      pkt_end;
		logic                      too_long;
	} cmd_t;

endpackage

// ----- src/mcps_if.sv -----
// Handshake channel interfaces for the serializer input items and output beats.
`timescale 1ns / 1ps

interface mcps_in_if;
	logic        valid;
	logic        ready;
	logic [2:0]  kind;
	logic [7:0]  sess_flag;
	logic [7:0]  conn_rc;
	logic [15:0] topic_length;
	logic [27:0] payload_length;
	logic [15:0] code_count;
	logic [15:0] pkt_ident;
	logic [1:0]  qos;
	logic        retain;
	logic [7:0]  data_byte;

	modport source (
		output valid, kind, sess_flag, conn_rc, topic_length,
		       payload_length, code_count, pkt_ident, qos, retain, data_byte,
		input  ready
	);
	modport sink (
		input  valid, kind, sess_flag, conn_rc, topic_length,
		       payload_length, code_count, pkt_ident, qos, retain, data_byte,
		output ready
	);
endinterface

interface mcps_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       run_last;
	logic       packet_end;
	logic       too_long;

	modport source (
		output valid, out_byte, run_last, packet_end, too_long,
		input  ready
	);
	modport sink (
		input  valid, out_byte, run_last, packet_end, too_long,
		output ready
	);
endinterface

// ----- src/mcps_front.sv -----
// Front end: accepts items, tracks the open packet and builds byte commands.
`timescale 1ns / 1ps

module mcps_front (
	input  logic           clk,
	input  logic           arst_n,
	mcps_in_if.sink        item,
	input  logic           q_full,
	output logic           push,
	output mcps_pkg::cmd_t cmd
);

	mcps_pkg::phase_t phase_q, phase_d;
	logic [27:0]      sect_q, sect_d;
	logic [27:0]      pay_q, pay_d;
	logic [15:0]      id_q, id_d;
	logic             idp_q, idp_d;

	logic        acc;
	logic        emit;
	logic [28:0] rem_pub;
	logic [27:0] rem_sel;
	logic [2:0]  nlen;
	logic [3:0][7:0] lenb;
	logic [mcps_pkg::CNT_W-1:0] pos;

	assign item.ready = !q_full;
	assign acc        = item.valid && item.ready;
	assign push       = acc && emit;

	// Remaining length and its variable-length encoding.
	always_comb begin
		rem_pub = 29'd2 + 29'(item.topic_length) + 29'(item.payload_length)
			+ ((item.qos != 2'd0) ? 29'd2 : 29'd0);
		if (item.kind == mcps_pkg::KIND_SUBACK) begin
			rem_sel = 28'd2 + 28'(item.code_count);
		end else begin
			rem_sel = rem_pub[27:0];
		end
		if (rem_sel < 28'd128) begin
			nlen = 3'd1;
		end else if (rem_sel < 28'd16384) begin
			nlen = 3'd2;
		end else if (rem_sel < 28'd2097152) begin
			nlen = 3'd3;
		end else begin
			nlen = 3'd4;
		end
		for (int i = 0; i < 4; i++) begin
			lenb[i] = {(3'(i) + 3'd1 < nlen), rem_sel[7*i +: 7]};
		end
	end

	always_comb begin
		phase_d = phase_q;
		sect_d  = sect_q;
		pay_d   = pay_q;
		id_d    = id_q;
		idp_d   = idp_q;
		cmd     = '0;
		pos     = '0;
		emit    = 1'b0;
		case (item.kind)
			mcps_pkg::KIND_CONNACK: begin
				phase_d = mcps_pkg::PH_IDLE;
				sect_d  = '0;
				pay_d   = '0;
				id_d    = '0;
				idp_d   = 1'b0;
				emit    = 1'b1;
				cmd.bytes[0] = mcps_pkg::CONNACK_HDR;
				cmd.bytes[1] = mcps_pkg::CONNACK_LEN;
				cmd.bytes[2] = item.sess_flag;
				cmd.bytes[3] = item.conn_rc;
				pos = 4'd4;
				cmd.pkt_end = 1'b1;
			end
			mcps_pkg::KIND_PUBLISH: begin
				phase_d = mcps_pkg::PH_IDLE;
				sect_d  = '0;
				pay_d   = '0;
				id_d    = '0;
				idp_d   = 1'b0;
				emit    = 1'b1;
				if (rem_pub[28]) begin
					cmd.bytes[0] = mcps_pkg::ZERO_BYTE;
					pos = 4'd1;
					cmd.too_long = 1'b1;
				end else begin
					cmd.bytes[pos] = mcps_pkg::PUBLISH_HDR | {5'd0, item.qos, item.retain};
					pos = pos + 4'd1;
					for (int i = 0; i < 4; i++) begin
						if (3'(i) < nlen) begin
							cmd.bytes[pos] = lenb[i];
							pos = pos + 4'd1;
						end
					end
					cmd.bytes[pos] = item.topic_length[15:8];
					pos = pos + 4'd1;
					cmd.bytes[pos] = item.topic_length[7:0];
					pos = pos + 4'd1;
					id_d  = item.pkt_ident;
					pay_d = item.payload_length;
					if (item.topic_length == 16'd0) begin
						// Empty topic: the packet id follows at once.
						if (item.qos != 2'd0) begin
							cmd.bytes[pos] = item.pkt_ident[15:8];
							pos = pos + 4'd1;
							cmd.bytes[pos] = item.pkt_ident[7:0];
							pos = pos + 4'd1;
						end
						if (item.payload_length == 28'd0) begin
							cmd.pkt_end = 1'b1;
						end else begin
							phase_d = mcps_pkg::PH_PAYLOAD;
							sect_d  = item.payload_length;
							pay_d   = '0;
						end
					end else begin
						phase_d = mcps_pkg::PH_TOPIC;
						sect_d  = 28'(item.topic_length);
						idp_d   = (item.qos != 2'd0);
					end
				end
			end
			mcps_pkg::KIND_SUBACK: begin
				phase_d = mcps_pkg::PH_IDLE;
				sect_d  = '0;
				pay_d   = '0;
				id_d    = '0;
				idp_d   = 1'b0;
				emit    = 1'b1;
				cmd.bytes[pos] = mcps_pkg::SUBACK_HDR;
				pos = pos + 4'd1;
				for (int i = 0; i < 4; i++) begin
					if (3'(i) < nlen) begin
						cmd.bytes[pos] = lenb[i];
						pos = pos + 4'd1;
					end
				end
				cmd.bytes[pos] = item.pkt_ident[15:8];
				pos = pos + 4'd1;
				cmd.bytes[pos] = item.pkt_ident[7:0];
				pos = pos + 4'd1;
				if (item.code_count == 16'd0) begin
					cmd.pkt_end = 1'b1;
				end else begin
					phase_d = mcps_pkg::PH_CODES;
					sect_d  = 28'(item.code_count);
				end
			end
			mcps_pkg::KIND_PINGRESP: begin
				phase_d = mcps_pkg::PH_IDLE;
				sect_d  = '0;
				pay_d   = '0;
				id_d    = '0;
				idp_d   = 1'b0;
				emit    = 1'b1;
				cmd.bytes[0] = mcps_pkg::PINGRESP_HDR;
				cmd.bytes[1] = mcps_pkg::ZERO_BYTE;
				pos = 4'd2;
				cmd.pkt_end = 1'b1;
			end
			mcps_pkg::KIND_BODY: begin
				if (phase_q != mcps_pkg::PH_IDLE) begin
					emit = 1'b1;
					cmd.bytes[pos] = item.data_byte;
					pos = pos + 4'd1;
					sect_d = sect_q - 28'd1;
					if (sect_d == 28'd0) begin
						if (phase_q == mcps_pkg::PH_TOPIC) begin
							// Topic done: insert the held packet id, if any, then open the payload or end the packet.
							if (idp_q) begin
								cmd.bytes[pos] = id_q[15:8];
								pos = pos + 4'd1;
								cmd.bytes[pos] = id_q[7:0];
								pos = pos + 4'd1;
							end
							idp_d = 1'b0;
							if (pay_q == 28'd0) begin
								phase_d = mcps_pkg::PH_IDLE;
								cmd.pkt_end = 1'b1;
							end else begin
								phase_d = mcps_pkg::PH_PAYLOAD;
								sect_d  = pay_q;
								pay_d   = '0;
							end
						end else begin
							phase_d = mcps_pkg::PH_IDLE;
							cmd.pkt_end = 1'b1;
						end
					end
				end
			end
			default: begin
			end
		endcase
		cmd.count = pos;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= mcps_pkg::PH_IDLE;
			sect_q  <= '0;
			pay_q   <= '0;
			id_q    <= '0;
			idp_q   <= 1'b0;
		end else if (acc) begin
			phase_q <= phase_d;
			sect_q  <= sect_d;
			pay_q   <= pay_d;
			id_q    <= id_d;
			idp_q   <= idp_d;
		end
	end

endmodule

// ----- src/mcps_queue.sv -----
// Small command queue that decouples the front end from the byte sequencer.
`timescale 1ns / 1ps

module mcps_queue #(
	parameter int Depth = mcps_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  mcps_pkg::cmd_t wr_data,
	output logic           full,
	input  logic           pop,
	output logic           rd_valid,
	output mcps_pkg::cmd_t rd_data
);

	localparam int PW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CW = $clog2(Depth + 1);

	mcps_pkg::cmd_t  mem_q [Depth];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   cnt_q;
	logic            do_push;
	logic            do_pop;

	assign full     = (cnt_q == CW'(Depth));
	assign rd_valid = (cnt_q != '0);
	assign rd_data  = mem_q[rd_ptr_q];
	assign do_push  = push && !full;
	assign do_pop   = pop && rd_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(Depth - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(Depth - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

// ----- src/mcps_back.sv -----
// Back end: plays each command out as one output beat per byte.
`timescale 1ns / 1ps

module mcps_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	input  mcps_pkg::cmd_t q_data,
	output logic           q_pop,
	mcps_out_if.source     result
);

	mcps_pkg::cmd_t             cur_q;
	logic [mcps_pkg::CNT_W-1:0] idx_q;
	logic                       cur_valid_q;
	logic                       last;
	logic                       advance;

	assign last    = (idx_q == cur_q.count - 4'd1);
	assign advance = result.valid && result.ready;
	assign q_pop   = q_valid && (!cur_valid_q || (advance && last));

	assign result.valid      = cur_valid_q;
	assign result.out_byte   = cur_q.bytes[idx_q];
	assign result.run_last   = last;
	assign result.packet_end = cur_q.pkt_end && last;
	assign result.too_long   = cur_q.too_long;

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q       <= '0;
		end else if (q_pop) begin
			cur_valid_q <= 1'b1;
			idx_q       <= '0;
		end else if (advance) begin
			if (last) begin
				cur_valid_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 4'd1;
			end
		end
	end

endmodule

// ----- src/mqtt_control_packet_serializer.sv -----
// Top level of the MQTT 3.1.1 control packet serializer.
`timescale 1ns / 1ps

// This block turns a stream of items into the byte stream of MQTT CONNACK, PUBLISH,
// SUBACK and PINGRESP packets, one byte per output beat. A start item produces the
// fixed header, the one to four byte remaining length and the topic length or packet
// id (up to nine beats); each body item produces one byte, plus the two packet id
// bytes when it closes the topic of a publish with nonzero QoS. A publish whose
// remaining length exceeds 268435455 gives a single beat with too_long set and opens
// no packet; body items while no packet is open, and unused kinds, give no beat.
// run_last marks the last beat of each item and packet_end the last byte of a
// packet. The front end takes one item per clock whenever its command queue
// (QueueDepth entries, four by default) has room, so body bytes stream at one item
// and one beat per cycle while the output stays ready. The back end emits one beat
// per cycle while result.ready is high, so a start item occupies the output for as
// many beats as it has bytes, one for a rejected publish and up to nine otherwise;
// the queue absorbs those bursts. An accepted item is written into the queue and
// then loaded into the back end's current command before its first beat is shown.

module mqtt_control_packet_serializer #(
	parameter int QueueDepth = mcps_pkg::QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	mcps_in_if.sink    item,
	mcps_out_if.source result
);

	mcps_pkg::cmd_t push_cmd;
	mcps_pkg::cmd_t pop_cmd;
	logic           push;
	logic           q_full;
	logic           q_valid;
	logic           q_pop;

	// Classifies items, keeps the open-packet state and builds byte commands.
	mcps_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.q_full (q_full),
		.push   (push),
		.cmd    (push_cmd)
	);

	// Lets the front keep accepting while the back plays out a long header.
	mcps_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_data  (push_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.rd_valid (q_valid),
		.rd_data  (pop_cmd)
	);

	// Emits each queued command byte by byte under output backpressure.
	mcps_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_data  (pop_cmd),
		.q_pop   (q_pop),
		.result  (result)
	);

endmodule

// ----- tb/sv/tb_mqtt_control_packet_serializer.sv -----
// Self-checking testbench for the MQTT control packet serializer top level.
`timescale 1ns / 1ps

module tb_mqtt_control_packet_serializer;

	// Largest remaining length that the four byte variable-length encoding can carry.
	localparam logic [31:0] MAX_REMAINING = 32'd268435455;
	// Cycles to let pass after the last expected beat, so that the command queue
	// (four entries of up to nine bytes) and the pipeline are surely empty.
	localparam int SETTLE_CYCLES = 60;
	// Hard stop for the whole run: far above the slowest legal run.
	localparam int CYCLE_LIMIT = 400000;
	// Length of the long receiver hold-off.
	localparam int HOLD_CYCLES = 150;

	// One input item as the sender offers it.
	typedef struct {
		logic [2:0]  kind;
		logic [7:0]  sess_flag;
		logic [7:0]  conn_rc;
		logic [15:0] topic_length;
		logic [27:0] payload_length;
		logic [15:0] code_count;
		logic [15:0] pkt_ident;
		logic [1:0]  qos;
		logic        retain;
		logic [7:0]  data_byte;
	} in_item_t;

	// One output beat as the receiver should see it.
	typedef struct {
		logic [7:0] out_byte;
		logic       run_last;
		logic       packet_end;
		logic       too_long;
	} beat_t;

	logic clk;
	logic arst_n;

	mcps_in_if  in_ch ();
	mcps_out_if out_ch ();

	mqtt_control_packet_serializer u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (in_ch),
		.result (out_ch)
	);

	// Packet state of the serializer as the testbench tracks it.
	mcps_pkg::phase_t m_phase;
	logic [27:0]      m_left;
	logic [27:0]      m_payload_left;
	logic [15:0]      m_pid;
	logic             m_id_due;

	// Bytes produced by the item being serialized, where its packet ends, and
	// whether it was a rejected publish.
	logic [7:0] burst_bytes[$];
	int         end_at;
	logic       rejected;

	// Beats still owed by the block, oldest first.
	beat_t pending_beats[$];

	int   errors = 0;
	int   cycle_count = 0;
	int   counted_items;
	int   send_idle_pct;
	int   recv_stall_pct;
	logic hold_active;
	event hold_go;

	// Clock: 10 ns period.
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog: a hung block must not keep the run going forever.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------

	function automatic void clear_packet_state();
		m_phase        = mcps_pkg::PH_IDLE;
		m_left         = '0;
		m_payload_left = '0;
		m_pid          = '0;
		m_id_due       = 1'b0;
	endfunction

	function automatic void emit_byte(logic [7:0] b);
		burst_bytes.insert(burst_bytes.size(), b);
	endfunction

	// The last byte produced so far closes the packet.
	function automatic void close_packet();
		if (burst_bytes.size() != 0)
			end_at = burst_bytes.size() - 1;
	endfunction

	// Variable-length remaining length: seven bits per byte, low group first,
	// bit 7 set while more groups follow.
	function automatic void emit_length(logic [27:0] len);
		logic [27:0] rest;
		logic [7:0]  b;
		rest = len;
		do begin
			b = {1'b0, rest[6:0]};
			rest = rest >> 7;
			if (rest != '0)
				b[7] = 1'b1;
			emit_byte(b);
		end while (rest != '0);
	endfunction

	// The topic of a publish is complete: the packet id goes out now when QoS
	// is nonzero, then either the payload opens or the packet is over.
	function automatic void finish_topic();
		if (m_id_due) begin
			emit_byte(m_pid[15:8]);
			emit_byte(m_pid[7:0]);
			m_id_due = 1'b0;
		end
		if (m_payload_left == '0) begin
			m_phase = mcps_pkg::PH_IDLE;
			m_left  = '0;
			close_packet();
		end else begin
			m_phase        = mcps_pkg::PH_PAYLOAD;
			m_left         = m_payload_left;
			m_payload_left = '0;
		end
	endfunction

	// Works out the beats one accepted item causes, queues them and returns how
	// many there are.
	function automatic int serialize_item(in_item_t it);
		logic [31:0] rem;
		beat_t       bt;
		burst_bytes.delete();
		end_at   = -1;
		rejected = 1'b0;
		case (it.kind)
			mcps_pkg::KIND_CONNACK: begin
				clear_packet_state();
				emit_byte(mcps_pkg::CONNACK_HDR);
				emit_byte(mcps_pkg::CONNACK_LEN);
				emit_byte(it.sess_flag);
				emit_byte(it.conn_rc);
				close_packet();
			end
			mcps_pkg::KIND_PUBLISH: begin
				rem = 32'd2 + 32'(it.topic_length) + 32'(it.payload_length)
				      + ((it.qos != 2'd0) ? 32'd2 : 32'd0);
				clear_packet_state();
				if (rem > MAX_REMAINING) begin
					emit_byte(mcps_pkg::ZERO_BYTE);
					rejected = 1'b1;
				end else begin
					emit_byte(mcps_pkg::PUBLISH_HDR | {5'd0, it.qos, it.retain});
					emit_length(rem[27:0]);
					emit_byte(it.topic_length[15:8]);
					emit_byte(it.topic_length[7:0]);
					m_pid          = it.pkt_ident;
					m_id_due       = (it.qos != 2'd0);
					m_payload_left = it.payload_length;
					if (it.topic_length == 16'd0) begin
						finish_topic();
					end else begin
						m_phase = mcps_pkg::PH_TOPIC;
						m_left  = 28'(it.topic_length);
					end
				end
			end
			mcps_pkg::KIND_SUBACK: begin
				clear_packet_state();
				emit_byte(mcps_pkg::SUBACK_HDR);
				emit_length(28'd2 + 28'(it.code_count));
				emit_byte(it.pkt_ident[15:8]);
				emit_byte(it.pkt_ident[7:0]);
				if (it.code_count == 16'd0) begin
					close_packet();
				end else begin
					m_phase = mcps_pkg::PH_CODES;
					m_left  = 28'(it.code_count);
				end
			end
			mcps_pkg::KIND_PINGRESP: begin
				clear_packet_state();
				emit_byte(mcps_pkg::PINGRESP_HDR);
				emit_byte(mcps_pkg::ZERO_BYTE);
				close_packet();
			end
			mcps_pkg::KIND_BODY: begin
				// A body byte with no open packet is simply dropped.
				if (m_phase != mcps_pkg::PH_IDLE) begin
					emit_byte(it.data_byte);
					m_left = m_left - 28'd1;
					if (m_left == '0) begin
						if (m_phase == mcps_pkg::PH_TOPIC) begin
							finish_topic();
						end else begin
							m_phase = mcps_pkg::PH_IDLE;
							close_packet();
						end
					end
				end
			end
			default: begin
				// Unused kinds leave everything as it was.
			end
		endcase
		for (int i = 0; i < burst_bytes.size(); i++) begin
			bt.out_byte   = burst_bytes[i];
			bt.run_last   = (i == burst_bytes.size() - 1);
			bt.packet_end = (i == end_at);
			bt.too_long   = rejected;
			pending_beats.insert(pending_beats.size(), bt);
		end
		return burst_bytes.size();
	endfunction

	// ------------------------------------------------------------------
	// Output side: ready with random stalls, plus a long hold-off on request
	// ------------------------------------------------------------------

	// The hold-off is counted here, one clock at a time.
	initial begin
		hold_active = 1'b0;
		forever begin
			@(hold_go);
			hold_active = 1'b1;
			repeat (HOLD_CYCLES) @(posedge clk);
			hold_active = 1'b0;
		end
	end

	initial begin
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			out_ch.ready = !hold_active && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Every accepted beat is compared field by field with the oldest expectation.
	always @(posedge clk) begin
		beat_t want;
		if (arst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
			if (pending_beats.size() == 0) begin
				$error("unexpected beat: out_byte %02h run_last %b packet_end %b too_long %b",
				       out_ch.out_byte, out_ch.run_last, out_ch.packet_end, out_ch.too_long);
				errors++;
			end else begin
				want = pending_beats.pop_front();
				if (out_ch.out_byte !== want.out_byte) begin
					$error("out_byte expected %02h got %02h", want.out_byte, out_ch.out_byte);
					errors++;
				end
				if (out_ch.run_last !== want.run_last) begin
					$error("run_last expected %b got %b", want.run_last, out_ch.run_last);
					errors++;
				end
				if (out_ch.packet_end !== want.packet_end) begin
					$error("packet_end expected %b got %b", want.packet_end, out_ch.packet_end);
					errors++;
				end
				if (out_ch.too_long !== want.too_long) begin
					$error("too_long expected %b got %b", want.too_long, out_ch.too_long);
					errors++;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Input side
	// ------------------------------------------------------------------

	function automatic in_item_t blank_item(logic [2:0] kind);
		in_item_t it;
		it.kind           = kind;
		it.sess_flag      = '0;
		it.conn_rc        = '0;
		it.topic_length   = '0;
		it.payload_length = '0;
		it.code_count     = '0;
		it.pkt_ident      = '0;
		it.qos            = '0;
		it.retain         = '0;
		it.data_byte      = '0;
		return it;
	endfunction

	function automatic in_item_t random_item();
		in_item_t it;
		it.kind           = 3'($urandom_range(0, 7));
		it.sess_flag      = 8'($urandom);
		it.conn_rc        = 8'($urandom);
		it.topic_length   = 16'($urandom);
		it.payload_length = 28'($urandom);
		it.code_count     = 16'($urandom);
		it.pkt_ident      = 16'($urandom);
		it.qos            = 2'($urandom);
		it.retain         = 1'($urandom);
		it.data_byte      = 8'($urandom);
		return it;
	endfunction

	// Offers one item, waits for the handshake and records the beats it causes.
	// Entered and left at a falling edge; valid is low again on the way out.
	task automatic send_item(input in_item_t it);
		while ($urandom_range(99) < send_idle_pct)
			@(negedge clk);
		in_ch.kind           = it.kind;
		in_ch.sess_flag      = it.sess_flag;
		in_ch.conn_rc        = it.conn_rc;
		in_ch.topic_length   = it.topic_length;
		in_ch.payload_length = it.payload_length;
		in_ch.code_count     = it.code_count;
		in_ch.pkt_ident      = it.pkt_ident;
		in_ch.qos            = it.qos;
		in_ch.retain         = it.retain;
		in_ch.data_byte      = it.data_byte;
		in_ch.valid          = 1'b1;
		@(posedge clk);
		while (in_ch.ready !== 1'b1)
			@(posedge clk);
		if (serialize_item(it) > 0)
			counted_items++;
		@(negedge clk);
		in_ch.valid = 1'b0;
	endtask

	// Body bytes with random content in every field that the block ignores.
	task automatic send_bodies(input int count);
		in_item_t it;
		for (int i = 0; i < count; i++) begin
			it      = random_item();
			it.kind = mcps_pkg::KIND_BODY;
			send_item(it);
		end
	endtask

	// Sender waits until every owed beat has arrived, then lets the pipeline empty.
	task automatic settle();
		while (pending_beats.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Sends the bytes a packet needs, now and then fewer than that, now and
	// then followed by stray bytes that must be dropped.
	task automatic send_packet_body(input int needed);
		int count;
		count = needed;
		if (needed > 0 && $urandom_range(9) == 0)
			count = $urandom_range(0, needed - 1);
		else if ($urandom_range(9) == 0)
			count = needed + $urandom_range(1, 2);
		send_bodies(count);
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Field extremes, every kind and each special case, with no idling.
	task automatic test_directed();
		in_item_t it;
		int       edge_lens[6];
		send_idle_pct  = 0;
		recv_stall_pct = 0;

		// A body byte with nothing open, and the unused kinds: no beats.
		it = blank_item(mcps_pkg::KIND_BODY);
		it.data_byte = 8'hFF;
		send_item(it);
		send_item(blank_item(3'd5));
		send_item(blank_item(3'd6));
		send_item(blank_item(3'd7));

		send_item(blank_item(mcps_pkg::KIND_CONNACK));
		it = blank_item(mcps_pkg::KIND_CONNACK);
		it.sess_flag = 8'hFF;
		it.conn_rc   = 8'hFF;
		send_item(it);
		send_item(blank_item(mcps_pkg::KIND_PINGRESP));

		// Empty topic and payload: the packet ends on the topic length bytes.
		send_item(blank_item(mcps_pkg::KIND_PUBLISH));
		// Empty topic with QoS one: the packet id follows at once and ends it.
		it = blank_item(mcps_pkg::KIND_PUBLISH);
		it.qos       = 2'd1;
		it.retain    = 1'b1;
		it.pkt_ident = 16'hFFFF;
		send_item(it);

		// QoS two: the id goes out right after the last topic byte.
		it = blank_item(mcps_pkg::KIND_PUBLISH);
		it.qos            = 2'd2;
		it.topic_length   = 16'd2;
		it.payload_length = 28'd1;
		it.pkt_ident      = 16'h1234;
		send_item(it);
		it = blank_item(mcps_pkg::KIND_BODY);
		it.data_byte = 8'h00;
		send_item(it);
		it.data_byte = 8'hFF;
		send_item(it);
		it.data_byte = 8'hA5;
		send_item(it);

		// QoS three behaves like any nonzero QoS.
		it = blank_item(mcps_pkg::KIND_PUBLISH);
		it.qos          = 2'd3;
		it.topic_length = 16'd1;
		it.pkt_ident    = 16'hABCD;
		send_item(it);
		send_bodies(1);

		// Suback with no codes, then with two.
		send_item(blank_item(mcps_pkg::KIND_SUBACK));
		it = blank_item(mcps_pkg::KIND_SUBACK);
		it.code_count = 16'd2;
		it.pkt_ident  = 16'hFFFF;
		send_item(it);
		send_bodies(2);

		// Remaining length exactly at the limit is accepted, one above is
		// rejected, and all fields at their top are rejected too.
		it = blank_item(mcps_pkg::KIND_PUBLISH);
		it.payload_length = 28'd268435453;
		send_item(it);
		it.payload_length = 28'd268435454;
		send_item(it);
		it = blank_item(mcps_pkg::KIND_PUBLISH);
		it.topic_length   = 16'hFFFF;
		it.payload_length = 28'hFFFFFFF;
		it.qos            = 2'd3;
		it.retain         = 1'b1;
		it.pkt_ident      = 16'hFFFF;
		send_item(it);
		// Nothing is open after a rejection, so this byte is dropped.
		send_bodies(1);

		// A start while a packet is open abandons it.
		it = blank_item(mcps_pkg::KIND_PUBLISH);
		it.topic_length = 16'd3;
		send_item(it);
		send_bodies(1);
		send_item(blank_item(mcps_pkg::KIND_CONNACK));
		send_bodies(1);

		// Remaining length on both sides of the one, two and three byte limits.
		edge_lens = '{125, 126, 16381, 16382, 2097149, 2097150};
		it = blank_item(mcps_pkg::KIND_PUBLISH);
		foreach (edge_lens[i]) begin
			it.payload_length = 28'(edge_lens[i]);
			send_item(it);
		end
		settle();
	endtask

	// Mostly well-formed packets with random content, some noise and some
	// packets with huge lengths that are abandoned early.
	task automatic test_random(input int idle_pct, input int stall_pct, input int target);
		in_item_t it;
		int       start_count;
		int       pick;
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		start_count    = counted_items;
		while (counted_items - start_count < target) begin
			pick = $urandom_range(99);
			it   = random_item();
			if (pick < 12) begin
				send_item(it);
			end else if (pick < 22) begin
				it.kind = $urandom_range(1) ? mcps_pkg::KIND_PUBLISH : mcps_pkg::KIND_SUBACK;
				send_item(it);
				send_bodies($urandom_range(0, 3));
			end else begin
				case ($urandom_range(0, 5))
					0: begin
						it.kind = mcps_pkg::KIND_CONNACK;
						send_item(it);
					end
					1: begin
						it.kind = mcps_pkg::KIND_PINGRESP;
						send_item(it);
					end
					5: begin
						it.kind       = mcps_pkg::KIND_SUBACK;
						it.code_count = 16'($urandom_range(0, 5));
						send_item(it);
						send_packet_body(it.code_count);
					end
					default: begin
						it.kind           = mcps_pkg::KIND_PUBLISH;
						it.topic_length   = 16'($urandom_range(0, 5));
						it.payload_length = 28'($urandom_range(0, 6));
						send_item(it);
						send_packet_body(it.topic_length + it.payload_length);
					end
				endcase
			end
		end
		settle();
	endtask

	// The receiver holds off for a long stretch while start items keep coming,
	// so the command queue fills and the input has to stall.
	task automatic test_backpressure();
		in_item_t it;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		-> hold_go;
		repeat (24) begin
			it                = random_item();
			it.kind           = $urandom_range(1) ? mcps_pkg::KIND_PUBLISH : mcps_pkg::KIND_SUBACK;
			it.topic_length   = 16'($urandom_range(0, 3));
			it.payload_length = 28'($urandom_range(0, 3));
			it.code_count     = 16'($urandom_range(0, 3));
			send_item(it);
		end
		settle();
	endtask

	initial begin
		counted_items  = 0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		clear_packet_state();

		arst_n               = 1'b0;
		in_ch.valid          = 1'b0;
		in_ch.kind           = '0;
		in_ch.sess_flag      = '0;
		in_ch.conn_rc        = '0;
		in_ch.topic_length   = '0;
		in_ch.payload_length = '0;
		in_ch.code_count     = '0;
		in_ch.pkt_ident      = '0;
		in_ch.qos            = '0;
		in_ch.retain         = '0;
		in_ch.data_byte      = '0;

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		test_random(0, 0, 22);
		test_random(58, 0, 22);
		test_random(0, 58, 22);
		test_random(10, 10, 22);
		test_backpressure();

		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

// ----- files.f -----
src/mcps_pkg.sv
src/mcps_if.sv
src/mcps_front.sv
src/mcps_queue.sv
src/mcps_back.sv
src/mqtt_control_packet_serializer.sv
tb/sv/tb_mqtt_control_packet_serializer.sv
